// File: sv/serial_frame_receiver_top_macros.svh
// Assertion macros for the serial frame receiver.
`ifndef SERIAL_FRAME_RECEIVER_TOP_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SFR_ASSERT_IMPLY(label, clk, rstn, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SFR_ASSERT_NEXT(label, clk, rstn, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// File: sv/sfr_pkg.sv
// Shared types and constants of the serial frame receiver.
package sfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 40;
    localparam int M_TUSER_W  = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INSTRUCTION_LIMIT = 2'd2;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST      = 8'd5;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST     = 8'd9;
    localparam logic [BYTE_W-1:0] INSTRUCTION_LIMIT_RST = 8'd10;

    // Frame end status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADSUM  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZEROLEN = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd3;

    // Result item kinds
    localparam logic ITEM_PAYLOAD = 1'b0;
    localparam logic ITEM_END     = 1'b1;

    localparam logic [BYTE_W-1:0] MIN_TOPIC_LEN = 8'd3;

endpackage

// File: sv/serial_frame_receiver_top.sv
// Serial frame receiver: header hunt, length count, checksum and payload split.
//
//  channel  | dir | handshake                 | content
//  ---------+-----+---------------------------+----------------------------------
//  s_       | in  | s_tvalid / s_tready       | s_tdata: rx_byte
//  m_       | out | m_tvalid / m_tready       | m_tdata: frame fields, m_tuser: kind
//  cfg_     | in  | cfg_valid / cfg_ready     | cfg_index, cfg_data (register write)
//
// One byte per cycle sustained while not stalled. From s_ accept to m_tvalid a byte passes
// an input register, then the phase/sum update feeding the result register.
// Byte processing stalls only while the result register is full and m_tready is
// low; s_tready drops once the input register is also held.
// aresetn is synchronous, active low; config returns to 5 / 9 / 10.
// cfg_ready is always high; writes are taken in any cycle.
`include "serial_frame_receiver_top_macros.svh"

module serial_frame_receiver_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sfr_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] rx_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] payload_byte, [15:8] frame_tag, [16] is_instruction,
    // [24:17] msg_type, [26:25] frame_status, [34:27] frame_length, [39:35] 0
    output logic [sfr_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [sfr_pkg::M_TUSER_W-1:0]   m_tuser,   // [0] item_type
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfr_pkg::BYTE_W-1:0]      cfg_data
);
    import sfr_pkg::*;

    typedef enum logic [1:0] {
        PH_H1,
        PH_H2,
        PH_LEN,
        PH_BODY
    } phase_t;

    // Configuration
    logic [BYTE_W-1:0] header_first_reg;
    logic [BYTE_W-1:0] header_second_reg;
    logic [BYTE_W-1:0] instr_limit_reg;

    // Input stage
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // Frame state
    phase_t            phase_reg,   phase_next;
    logic [BYTE_W-1:0] length_reg,  length_next;
    logic [BYTE_W-1:0] index_reg,   index_next;
    logic [BYTE_W-1:0] sum_reg,     sum_next;
    logic [BYTE_W-1:0] tag_reg,     tag_next;
    logic [BYTE_W-1:0] type_reg,    type_next;

    // Result stage
    logic                out_valid_reg;
    logic                out_kind_reg;
    logic [BYTE_W-1:0]   out_payload_reg;
    logic [BYTE_W-1:0]   out_tag_reg;
    logic                out_instr_reg;
    logic [BYTE_W-1:0]   out_type_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [BYTE_W-1:0]   out_length_reg;

    logic                res_valid;
    logic                res_kind;
    logic [BYTE_W-1:0]   res_payload;
    logic [BYTE_W-1:0]   res_tag;
    logic                res_instr;
    logic [BYTE_W-1:0]   res_type;
    logic [STATUS_W-1:0] res_status;
    logic [BYTE_W-1:0]   res_length;

    logic              proc;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] tag_cur;
    logic [BYTE_W-1:0] index_inc;
    logic              instr;
    logic              last;

    assign proc      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc;
    assign cfg_ready = 1'b1;

    assign b         = in_byte_reg;
    assign tag_cur   = (index_reg == '0) ? b : tag_reg;
    assign index_inc = index_reg + BYTE_W'(1);
    assign instr     = tag_cur < instr_limit_reg;
    assign last      = index_inc >= length_reg;

    always_comb begin
        phase_next  = phase_reg;
        length_next = length_reg;
        index_next  = index_reg;
        sum_next    = sum_reg;
        tag_next    = tag_reg;
        type_next   = type_reg;
        res_valid   = 1'b0;
        res_kind    = ITEM_PAYLOAD;
        res_payload = '0;
        res_tag     = '0;
        res_instr   = 1'b0;
        res_type    = '0;
        res_status  = ST_OK;
        res_length  = '0;
        if (proc) begin
            unique case (phase_reg)
                PH_H1: begin
                    if (b == header_first_reg) begin
                        phase_next = PH_H2;
                    end
                end
                PH_H2: begin
                    // second byte wins when both header bytes are equal
                    if (b == header_second_reg) begin
                        phase_next = PH_LEN;
                    end else if (b != header_first_reg) begin
                        phase_next = PH_H1;
                    end
                end
                PH_LEN: begin
                    length_next = b;
                    index_next  = '0;
                    sum_next    = b;
                    tag_next    = '0;
                    type_next   = '0;
                    if (b == '0) begin
                        phase_next = PH_H1;
                        res_valid  = 1'b1;
                        res_kind   = ITEM_END;
                        res_status = ST_ZEROLEN;
                    end else begin
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY: begin
                    tag_next = tag_cur;
                    if (last) begin
                        // checksum byte closes the frame
                        phase_next  = PH_H1;
                        index_next  = '0;
                        res_valid   = 1'b1;
                        res_kind    = ITEM_END;
                        res_tag     = tag_cur;
                        res_instr   = instr;
                        res_type    = instr ? '0 : type_reg;
                        res_length  = length_reg;
                        if (sum_reg != b) begin
                            res_status = ST_BADSUM;
                        end else if (!instr && (length_reg < MIN_TOPIC_LEN)) begin
                            res_status = ST_SHORT;
                        end else begin
                            res_status = ST_OK;
                        end
                    end else begin
                        sum_next   = sum_reg + b;
                        index_next = index_inc;
                        if ((index_reg == BYTE_W'(1)) && !instr) begin
                            type_next = b;
                        end
                        if ((index_reg >= BYTE_W'(2)) && !instr) begin
                            res_valid   = 1'b1;
                            res_kind    = ITEM_PAYLOAD;
                            res_payload = b;
                            res_tag     = tag_cur;
                            res_type    = type_reg;
                            res_length  = length_reg;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_first_reg  <= HEADER_FIRST_RST;
            header_second_reg <= HEADER_SECOND_RST;
            instr_limit_reg   <= INSTRUCTION_LIMIT_RST;
            in_valid_reg      <= 1'b0;
            phase_reg         <= PH_H1;
            length_reg        <= '0;
            index_reg         <= '0;
            sum_reg           <= '0;
            tag_reg           <= '0;
            type_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_HEADER_FIRST:      header_first_reg  <= cfg_data;
                    CFG_HEADER_SECOND:     header_second_reg <= cfg_data;
                    CFG_INSTRUCTION_LIMIT: instr_limit_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            phase_reg  <= phase_next;
            length_reg <= length_next;
            index_reg  <= index_next;
            sum_reg    <= sum_next;
            tag_reg    <= tag_next;
            type_reg   <= type_next;
            if (proc) begin
                out_valid_reg <= res_valid;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
        if (proc) begin
            out_kind_reg    <= res_kind;
            out_payload_reg <= res_payload;
            out_tag_reg     <= res_tag;
            out_instr_reg   <= res_instr;
            out_type_reg    <= res_type;
            out_status_reg  <= res_status;
            out_length_reg  <= res_length;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {5'b0, out_length_reg, out_status_reg, out_type_reg,
                       out_instr_reg, out_tag_reg, out_payload_reg};

    `SFR_ASSERT_IMPLY(a_payload_ok, aclk, aresetn,
        m_tvalid && (m_tuser[0] == ITEM_PAYLOAD),
        (m_tdata[26:25] == ST_OK) && !m_tdata[16], "payload item from non-topic frame")
    `SFR_ASSERT_IMPLY(a_zerolen_clear, aclk, aresetn,
        m_tvalid && (m_tdata[26:25] == ST_ZEROLEN),
        (m_tdata[34:27] == '0) && (m_tdata[15:8] == '0) && (m_tuser[0] == ITEM_END),
        "zero-length report carries stale fields")
    `SFR_ASSERT_NEXT(a_len_to_body, aclk, aresetn,
        proc && (phase_reg == PH_LEN) && (b != '0),
        (phase_reg == PH_BODY) && (index_reg == '0), "length byte did not open body")
    `SFR_ASSERT_NEXT(a_result_shown, aclk, aresetn,
        proc && res_valid, m_tvalid, "result lost on its way to the output register")
    `SFR_ASSERT_IMPLY(a_stall_held, aclk, aresetn,
        !s_tready, in_valid_reg && out_valid_reg && !m_tready,
        "input stalled without a full pipeline")

endmodule

// File: bench/sfr_report_checker.sv
// Checker for the serial frame receiver: tracks the channels, predicts reports, compares them.
`timescale 1ns / 1ps

module sfr_report_checker
    import sfr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,    // [7:0] rx_byte
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] payload_byte, [15:8] frame_tag, [16] is_instruction,
    // [24:17] msg_type, [26:25] frame_status, [34:27] frame_length
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic [M_TUSER_W-1:0]  m_tuser,    // [0] item_type
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [BYTE_W-1:0]     cfg_data,
    output int                    error_count,
    output int                    outstanding,
    output int                    checked_count
);

    typedef enum logic [1:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        READ_LENGTH,
        READ_BODY
    } hunt_t;

    typedef struct {
        logic                kind;
        logic [BYTE_W-1:0]   payload;
        logic [BYTE_W-1:0]   tag;
        logic                instr;
        logic [BYTE_W-1:0]   mtype;
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   length;
    } report_t;

    // predictor copy of the block's registers and state
    logic [BYTE_W-1:0] hdr_first;
    logic [BYTE_W-1:0] hdr_second;
    logic [BYTE_W-1:0] instr_limit;
    hunt_t             phase;
    logic [BYTE_W-1:0] frame_len;
    logic [BYTE_W-1:0] body_idx;
    logic [BYTE_W-1:0] csum;
    logic [BYTE_W-1:0] frame_tag;
    logic [BYTE_W-1:0] frame_type;

    report_t expected_reports[$];
    report_t want;

    initial begin
        error_count   = 0;
        outstanding   = 0;
        checked_count = 0;
    end

    function automatic report_t blank_report();
        report_t r;
        r.kind    = ITEM_PAYLOAD;
        r.payload = '0;
        r.tag     = '0;
        r.instr   = 1'b0;
        r.mtype   = '0;
        r.status  = ST_OK;
        r.length  = '0;
        return r;
    endfunction

    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        report_t           r;
        logic              instr;
        logic              last;
        logic [BYTE_W-1:0] idx;
        r = blank_report();
        case (phase)
            HUNT_FIRST: begin
                if (b == hdr_first) phase = HUNT_SECOND;
            end
            HUNT_SECOND: begin
                // second header byte is tested first, so equal headers complete here
                if (b == hdr_second) phase = READ_LENGTH;
                else if (b != hdr_first) phase = HUNT_FIRST;
            end
            READ_LENGTH: begin
                frame_len  = b;
                body_idx   = '0;
                csum       = b;
                frame_tag  = '0;
                frame_type = '0;
                if (b == '0) begin
                    phase    = HUNT_FIRST;
                    r.kind   = ITEM_END;
                    r.status = ST_ZEROLEN;
                    expected_reports.push_back(r);
                end else begin
                    phase = READ_BODY;
                end
            end
            default: begin
                if (body_idx == '0) frame_tag = b;
                instr = frame_tag < instr_limit;
                last  = BYTE_W'(body_idx + 8'd1) >= frame_len;
                if (last) begin
                    r.kind   = ITEM_END;
                    r.tag    = frame_tag;
                    r.instr  = instr;
                    r.mtype  = instr ? '0 : frame_type;
                    r.length = frame_len;
                    // checksum error outranks the short topic frame
                    if (csum != b) r.status = ST_BADSUM;
                    else if (!instr && frame_len < MIN_TOPIC_LEN) r.status = ST_SHORT;
                    else r.status = ST_OK;
                    expected_reports.push_back(r);
                    phase    = HUNT_FIRST;
                    body_idx = '0;
                end else begin
                    csum = csum + b;
                    if (body_idx == 8'd1 && !instr) frame_type = b;
                    idx      = body_idx;
                    body_idx = body_idx + 8'd1;
                    if (idx >= 8'd2 && !instr) begin
                        r.kind    = ITEM_PAYLOAD;
                        r.payload = b;
                        r.tag     = frame_tag;
                        r.mtype   = frame_type;
                        r.length  = frame_len;
                        expected_reports.push_back(r);
                    end
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            hdr_first   = HEADER_FIRST_RST;
            hdr_second  = HEADER_SECOND_RST;
            instr_limit = INSTRUCTION_LIMIT_RST;
            phase       = HUNT_FIRST;
            frame_len   = '0;
            body_idx    = '0;
            csum        = '0;
            frame_tag   = '0;
            frame_type  = '0;
            expected_reports.delete();
        end else begin
            // a result leaves only after its byte has passed the input and result registers, so compare first
            if (m_tvalid && m_tready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: result item with nothing expected, actual tdata %h tuser %h",
                             $time, m_tdata, m_tuser);
                    error_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("item_type", want.kind, m_tuser[0]);
                    check_field("payload_byte", want.payload, m_tdata[7:0]);
                    check_field("frame_tag", want.tag, m_tdata[15:8]);
                    check_field("is_instruction", want.instr, m_tdata[16]);
                    check_field("msg_type", want.mtype, m_tdata[24:17]);
                    check_field("frame_status", want.status, m_tdata[26:25]);
                    check_field("frame_length", want.length, m_tdata[34:27]);
                    checked_count++;
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_HEADER_FIRST:      hdr_first   = cfg_data;
                    CFG_HEADER_SECOND:     hdr_second  = cfg_data;
                    CFG_INSTRUCTION_LIMIT: instr_limit = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) deframe_byte(s_tdata);
        end
        outstanding = expected_reports.size();
    end

endmodule

// File: bench/tb_serial_frame_receiver_top.sv
// Testbench top for the serial frame receiver: clock, reset, byte and register stimulus, verdict.
`timescale 1ns / 1ps

module tb_serial_frame_receiver_top;
    import sfr_pkg::*;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AT_RESULT = 50;
    localparam int PHASE_ITEMS    = 45;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;     // [7:0] rx_byte
    logic                 m_tvalid;
    logic                 m_tready;
    // [7:0] payload_byte, [15:8] frame_tag, [16] is_instruction,
    // [24:17] msg_type, [26:25] frame_status, [34:27] frame_length
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;     // [0] item_type
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;

    int error_count;
    int outstanding;
    int checked_count;

    int   cycle_count;
    int   bytes_sent;
    int   results_taken;
    int   reg_writes;
    logic no_idle;

    logic [BYTE_W-1:0] cur_first;
    logic [BYTE_W-1:0] cur_second;
    logic [BYTE_W-1:0] cur_limit;

    serial_frame_receiver_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sfr_report_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .outstanding   (outstanding),
        .checked_count (checked_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, outstanding);
            $display("simulation failed");
            $finish;
        end
    end

    // result side: random hold-offs per item, plus one long stall
    initial begin : result_sink
        int  gap;
        bit  hold_done;
        hold_done     = 1'b0;
        results_taken = 0;
        m_tready      = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (!hold_done && results_taken >= HOLD_AT_RESULT) begin
                hold_done = 1'b1;
                m_tready  = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            results_taken++;
            @(negedge aclk);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // header, length, body; the last body byte carries the checksum
    task automatic send_frame(input logic [BYTE_W-1:0] len, input logic [BYTE_W-1:0] tag,
                              input logic [BYTE_W-1:0] mtype, input bit bad_sum);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        send_byte(cur_first);
        send_byte(cur_second);
        send_byte(len);
        sum = len;
        for (int i = 0; i < len; i++) begin
            if (i == len - 1) begin
                b = bad_sum ? sum + BYTE_W'($urandom_range(1, 255)) : sum;
            end else if (i == 0) begin
                b = tag;
            end else if (i == 1) begin
                b = mtype;
            end else begin
                case ($urandom_range(0, 5))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = BYTE_W'($urandom_range(0, 255));
                endcase
            end
            sum = sum + b;
            send_byte(b);
        end
    endtask

    function automatic logic [BYTE_W-1:0] pick_tag();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return cur_limit - 8'd1;
            2:       return cur_limit;
            3:       return 8'hFF;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // block may still be chewing a byte that makes no result
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
        reg_writes++;
        case (idx)
            CFG_HEADER_FIRST:      cur_first  = val;
            CFG_HEADER_SECOND:     cur_second = val;
            CFG_INSTRUCTION_LIMIT: cur_limit  = val;
            default: ;
        endcase
    endtask

    task automatic random_action();
        int n;
        logic [BYTE_W-1:0] len;
        n = $urandom_range(0, 19);
        if (n < 14) begin
            len = ($urandom_range(0, 7) == 0) ? BYTE_W'($urandom_range(1, 3))
                                              : BYTE_W'($urandom_range(1, 12));
            send_frame(len, pick_tag(), BYTE_W'($urandom_range(0, 255)), 1'b0);
        end else if (n < 16) begin
            send_frame(BYTE_W'($urandom_range(1, 12)), pick_tag(),
                       BYTE_W'($urandom_range(0, 255)), 1'b1);
        end else if (n < 18) begin
            repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom_range(0, 255)));
        end else if (n == 18) begin
            // header cut short, then a stray byte
            send_byte(cur_first);
            if ($urandom_range(0, 1)) send_byte(cur_first);
            send_byte(BYTE_W'($urandom_range(0, 255)));
        end else begin
            send_byte(cur_first);
            send_byte(cur_first);
            send_byte(cur_second);
            send_byte(8'h00);
        end
    endtask

    initial begin : stimulus
        int phase_end;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_HEADER_FIRST;
        cfg_data   = '0;
        no_idle    = 1'b0;
        bytes_sent = 0;
        reg_writes = 0;
        cur_first  = HEADER_FIRST_RST;
        cur_second = HEADER_SECOND_RST;
        cur_limit  = INSTRUCTION_LIMIT_RST;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed, reset register values
        send_byte(cur_first);                     // repeated first header byte
        send_byte(cur_first);
        send_byte(cur_second);
        send_byte(8'h00);                         // zero length
        send_frame(8'd1, 8'd0, 8'd0, 1'b0);       // tag doubles as checksum
        send_frame(8'd2, 8'hFF, 8'd0, 1'b0);      // topic too short
        send_frame(8'd2, 8'd200, 8'd0, 1'b1);     // bad sum beats too short
        send_frame(8'd4, cur_limit, 8'd7, 1'b0);  // tag at the limit is a topic

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                wait_idle();
                case (ph)
                    1: begin
                        write_reg(CFG_HEADER_FIRST, 8'h00);
                        write_reg(CFG_HEADER_SECOND, 8'hFF);
                        write_reg(CFG_INSTRUCTION_LIMIT, 8'h00);
                    end
                    2: begin
                        write_reg(CFG_HEADER_FIRST, 8'hFF);
                        write_reg(CFG_HEADER_SECOND, 8'h00);
                        write_reg(CFG_INSTRUCTION_LIMIT, 8'hFF);
                    end
                    3: begin
                        // equal header bytes
                        write_reg(CFG_HEADER_FIRST, 8'hA5);
                        write_reg(CFG_HEADER_SECOND, 8'hA5);
                        write_reg(CFG_INSTRUCTION_LIMIT, 8'h80);
                        write_reg(CFG_UNUSED_INDEX, BYTE_W'($urandom_range(0, 255)));
                    end
                    default: begin
                        write_reg(CFG_INSTRUCTION_LIMIT, BYTE_W'($urandom_range(0, 255)));
                        write_reg(CFG_HEADER_SECOND, BYTE_W'($urandom_range(0, 255)));
                        write_reg(CFG_HEADER_FIRST, BYTE_W'($urandom_range(0, 255)));
                    end
                endcase
            end
            phase_end = bytes_sent + PHASE_ITEMS;
            if (ph == 1) send_frame(8'hFF, pick_tag(), BYTE_W'($urandom_range(0, 255)), 1'b0);
            while (bytes_sent < phase_end) begin
                no_idle = ($urandom_range(0, 4) == 0);
                random_action();
            end
            no_idle = 1'b0;
        end

        wait_idle();
        $display("sent %0d bytes over six register settings, %0d register writes",
                 bytes_sent, reg_writes);
        $display("checked %0d payload items and frame reports", checked_count);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", error_count);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: serial_frame_receiver_top.f
+incdir+sv
sv/sfr_pkg.sv
sv/serial_frame_receiver_top.sv
bench/sfr_report_checker.sv
bench/tb_serial_frame_receiver_top.sv
